FILE: sv/via_pkg.sv
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes and request/result payload types of the integer ALU.
// ----------------------------------------------------------------------------
package via_pkg;

  localparam int unsigned FieldWidth = 64;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_FDIV  = 4'd3,
    OP_FMOD  = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_AND   = 4'd7,
    OP_OR    = 4'd8,
    OP_XOR   = 4'd9,
    OP_PASS  = 4'd10,
    OP_NEG   = 4'd11,
    OP_NOT   = 4'd12,
    OP_RSV13 = 4'd13,
    OP_RSV14 = 4'd14,
    OP_RSV15 = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]                   cmd;
    logic signed [FieldWidth-1:0] operand_a;
    logic signed [FieldWidth-1:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] result_value;
    logic                         divide_by_zero;
  } out_res_t;

endpackage

FILE: sv/vm_integer_alu_core.sv
// ----------------------------------------------------------------------------
// Integer ALU core
// Wrapping add, sub, mul, floor div/mod, shifts, logic ops, pass and negate.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with in_req (cmd, operand_a, operand_b).
// Results leave on out_valid/out_ready with out_res (result_value and
// divide_by_zero). Every request goes through the same pipeline: the prep
// register, DATA_WIDTH division cells and the output register, with the
// fix-up logic in front of the output register. One request is accepted per
// cycle while the pipeline is not frozen; each division cell resolves one
// quotient bit.
// The whole pipeline advances together; when out_ready is low while a result
// is held, the pipeline freezes and in_ready drops.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module vm_integer_alu_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  via_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output via_pkg::out_res_t out_res
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned FW = via_pkg::FieldWidth;
  localparam int unsigned SW = $clog2(W);
  localparam int unsigned LW = (W + 1) / 2;
  localparam int unsigned HW = W - LW;

  typedef struct packed {
    logic [W-1:0] fast;
    logic         use_div;
    logic         is_mod;
    logic         dz;
    logic         neg_a;
    logic         neg_b;
    logic [W-1:0] b;
  } side_t;

  logic          en;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W-1:0]  cnt_mag;
  logic          cnt_neg;
  logic          cnt_big;
  logic [W-1:0]  shl_v;
  logic [W-1:0]  shr_v;
  logic [W-1:0]  fast_nxt;
  logic          b_zero;
  logic          b_one;
  logic          b_m1;
  side_t         side_nxt;
  side_t         side_r [W+1];
  logic          is_mul_r;

  logic [LW-1:0]   a_lo;
  logic [LW-1:0]   b_lo;
  logic [HW-1:0]   a_hi;
  logic [HW-1:0]   b_hi;
  logic [2*LW-1:0] mul_ll;
  logic [HW-1:0]   mul_lh;
  logic [HW-1:0]   mul_hl;
  logic [2*LW-1:0] pll_r;
  logic [HW-1:0]   plh_r;
  logic [HW-1:0]   phl_r;
  logic [HW-1:0]   cross_sum;

  logic          vld_c [W+1];
  logic [W-1:0]  rem_c [W+1];
  logic [W-1:0]  quo_c [W+1];
  logic [W-1:0]  dvs_c [W+1];
  logic [W-1:0]  prod_d [W+1];
  logic          mul_d [W+1];

  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  res_nxt;
  logic          out_valid_r;
  via_pkg::out_res_t out_res_r;
  logic          fix_vld;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    a       = in_req.operand_a[W-1:0];
    b       = in_req.operand_b[W-1:0];
    mag_a   = a[W-1] ? -a : a;
    mag_b   = b[W-1] ? -b : b;
    b_zero  = (b == '0);
    b_one   = (b == {{(W-1){1'b0}}, 1'b1});
    b_m1    = (b == '1);
    cnt_neg = b[W-1];
    cnt_mag = mag_b;
    cnt_big = (cnt_mag >= W'(W));
    shl_v   = cnt_big ? '0 : (a << cnt_mag[SW-1:0]);
    shr_v   = cnt_big ? '0 : (a >> cnt_mag[SW-1:0]);
    fast_nxt = '0;
    unique case (via_pkg::op_t'(in_req.cmd))
      via_pkg::OP_ADD:  fast_nxt = a + b;
      via_pkg::OP_SUB:  fast_nxt = a - b;
      via_pkg::OP_MUL:  fast_nxt = '0;
      via_pkg::OP_FDIV: fast_nxt = b_m1 ? -a : (b_one ? a : '0);
      via_pkg::OP_FMOD: fast_nxt = '0;
      via_pkg::OP_SHL:  fast_nxt = cnt_neg ? shr_v : shl_v;
      via_pkg::OP_SHR:  fast_nxt = cnt_neg ? shl_v : shr_v;
      via_pkg::OP_AND:  fast_nxt = a & b;
      via_pkg::OP_OR:   fast_nxt = a | b;
      via_pkg::OP_XOR:  fast_nxt = a ^ b;
      via_pkg::OP_PASS: fast_nxt = a;
      via_pkg::OP_NEG:  fast_nxt = -a;
      via_pkg::OP_NOT:  fast_nxt = ~a;
      default:          fast_nxt = '0;
    endcase
    side_nxt.fast    = fast_nxt;
    side_nxt.is_mod  = (in_req.cmd == via_pkg::OP_FMOD);
    side_nxt.dz      = ((in_req.cmd == via_pkg::OP_FDIV) ||
                        (in_req.cmd == via_pkg::OP_FMOD)) && b_zero;
    side_nxt.use_div = ((in_req.cmd == via_pkg::OP_FDIV) && !b_zero && !b_one && !b_m1) ||
                       ((in_req.cmd == via_pkg::OP_FMOD) && !b_zero && !b_one && !b_m1);
    side_nxt.neg_a   = a[W-1];
    side_nxt.neg_b   = b[W-1];
    side_nxt.b       = b;
  end

  assign a_lo   = a[LW-1:0];
  assign b_lo   = b[LW-1:0];
  assign a_hi   = a[W-1:LW];
  assign b_hi   = b[W-1:LW];
  assign mul_ll = (2*LW)'(a_lo) * (2*LW)'(b_lo);
  assign mul_lh = HW'(a_lo) * b_hi;
  assign mul_hl = a_hi * HW'(b_lo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c[0] <= 1'b0;
    end else if (en) begin
      vld_c[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      rem_c[0]  <= '0;
      quo_c[0]  <= mag_a;
      dvs_c[0]  <= mag_b;
      pll_r     <= mul_ll;
      plh_r     <= mul_lh;
      phl_r     <= mul_hl;
      is_mul_r  <= (in_req.cmd == via_pkg::OP_MUL);
    end
  end

  assign cross_sum = plh_r + phl_r;
  assign prod_d[0] = W'(pll_r) + {cross_sum, {LW{1'b0}}};
  assign mul_d[0]  = is_mul_r;

  for (genvar i = 0; i < W; i++) begin : g_cell
    via_div_cell #(.W(W), .BIT(W-1-i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_c[i]),
      .rem_i (rem_c[i]),
      .quo_i (quo_c[i]),
      .dvs_i (dvs_c[i]),
      .vld_o (vld_c[i+1]),
      .rem_o (rem_c[i+1]),
      .quo_o (quo_c[i+1]),
      .dvs_o (dvs_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        prod_d[i+1] <= prod_d[i];
        mul_d[i+1]  <= mul_d[i];
      end
    end
  end

  always_comb begin
    side_t s;
    s = side_r[W];
    q = quo_c[W];
    r = rem_c[W];
    if (mul_d[W]) begin
      res_nxt = prod_d[W];
    end else if (!s.use_div) begin
      res_nxt = s.fast;
    end else if (s.is_mod) begin
      res_nxt = s.neg_a ? -r : r;
      if ((r != '0) && (s.neg_a != s.neg_b)) res_nxt = res_nxt + s.b;
    end else begin
      res_nxt = q;
      if (s.neg_a != s.neg_b) begin
        res_nxt = -q;
        if (r != '0) res_nxt = res_nxt - W'(1);
      end
    end
  end

  assign fix_vld = vld_c[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fix_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r.result_value   <= FW'($signed(res_nxt));
      out_res_r.divide_by_zero <= side_r[W].dz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed under stall");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted a request while frozen");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.divide_by_zero |-> out_res.result_value == '0)
    else $error("divide by zero with nonzero result");

endmodule

FILE: sv/via_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step on magnitudes, plus a pass-along of the request.
// ----------------------------------------------------------------------------
module via_div_cell #(
  parameter int unsigned W = 64,
  parameter int unsigned BIT = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] dvs_i,
  output logic         vld_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] dvs_o
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;
  logic         vld_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] quo_r;
  logic [W-1:0] dvs_r;

  always_comb begin
    trial   = {rem_i, quo_i[BIT]};
    diff    = trial - {1'b0, dvs_i};
    quo_nxt = quo_i;
    if (!diff[W]) begin
      rem_nxt      = diff[W-1:0];
      quo_nxt[BIT] = 1'b1;
    end else begin
      rem_nxt      = trial[W-1:0];
      quo_nxt[BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dvs_o = dvs_r;

endmodule
